### src/spfd_pkg.sv
// Shared types and constants for the scan/peak frame decoder.
// Used by every module of the block; depends on nothing.
package spfd_pkg;

    // Largest scan count the count table holds
    localparam int MAX_SCANS = 1024;
    localparam int SCAN_W    = (MAX_SCANS > 1) ? $clog2(MAX_SCANS) : 1;
    // Header position and effective scan count also hold MAX_SCANS itself
    localparam int HPOS_W    = SCAN_W + 1;

    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 31;
    localparam int SCANCFG_W  = 11;
    localparam int OUT_SCAN_W = 10;

    // Queue between front and back; depth is a power of two so pointers wrap
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_TOTAL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_GAIN = 2'd2;

    localparam logic [SCANCFG_W-1:0] SCAN_COUNT_RST     = 11'd1;
    localparam logic [WORD_W-1:0]    PEAK_TOTAL_RST     = 32'd0;
    localparam logic [WORD_W-1:0]    INTENSITY_GAIN_RST = 32'd65536;

    // Rounding offset for Q16.16: one half
    localparam logic [2*WORD_W-1:0] ROUND_HALF = 64'h8000;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              frame_start;
    } word_t;

    typedef struct packed {
        logic [OUT_SCAN_W-1:0] scan_index;
        logic [WORD_W-1:0]     tof_value;
        logic [WORD_W-1:0]     scaled_intensity;
        logic [WORD_W-1:0]     peak_number;
        logic                  last_peak;
        logic                  overrun;
    } peak_t;

    // One classified intensity item, handed from front to back
    typedef struct packed {
        logic [SCAN_W-1:0] scan;
        logic [WORD_W-1:0] tof;
        logic [WORD_W-1:0] intensity;
        logic [WORD_W-1:0] peak_number;
        logic              last_peak;
        logic              overrun;
    } job_t;

endpackage

### src/spfd_front.sv
// Front part of the frame decoder: accepts words, fills the count table,
// tracks scan position and tof, and hands intensity items to the queue.
// Depends on spfd_pkg.
module spfd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                word_valid,
    input  spfd_pkg::word_t                     word,
    output logic                                word_stall,
    input  logic [spfd_pkg::SCANCFG_W-1:0]      scan_count,
    input  logic [spfd_pkg::WORD_W-1:0]         peak_total,
    input  logic                                q_full,
    output logic                                push,
    output spfd_pkg::job_t                      push_job
);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_LOOK  = 3'b010,
        ST_CHECK = 3'b100
    } front_state_t;

    front_state_t                    state_reg, state_next;
    logic                            in_header_reg, in_header_next;
    logic [spfd_pkg::HPOS_W-1:0]     hdr_pos_reg, hdr_pos_next;
    logic [spfd_pkg::SCAN_W-1:0]     cur_scan_reg, cur_scan_next;
    logic [spfd_pkg::COUNT_W-1:0]    peaks_left_reg, peaks_left_next;
    logic [spfd_pkg::WORD_W-1:0]     tof_acc_reg, tof_acc_next;
    logic [spfd_pkg::WORD_W-1:0]     held_tof_reg, held_tof_next;
    logic                            expect_reg, expect_next;
    logic [spfd_pkg::WORD_W-1:0]     peaks_done_reg, peaks_done_next;

    // Count table
    logic [spfd_pkg::COUNT_W-1:0]    table_mem [spfd_pkg::MAX_SCANS];
    logic [spfd_pkg::COUNT_W-1:0]    rd_data_reg;
    logic                            rd_en;
    logic                            wr_en;
    logic [spfd_pkg::SCAN_W-1:0]     wr_addr;
    logic [spfd_pkg::COUNT_W-1:0]    wr_data;

    logic                            accept;
    logic                            start;
    logic [spfd_pkg::HPOS_W-1:0]     n_eff;
    logic [spfd_pkg::SCAN_W-1:0]     last_scan;
    logic                            eff_header;
    logic [spfd_pkg::HPOS_W-1:0]     eff_pos;
    logic [spfd_pkg::HPOS_W-1:0]     pos_inc;
    logic                            eff_expect;
    logic [spfd_pkg::WORD_W-1:0]     eff_done;
    logic [spfd_pkg::SCAN_W-1:0]     eff_cur;
    logic [spfd_pkg::COUNT_W-1:0]    eff_left;
    logic [spfd_pkg::COUNT_W-1:0]    left_dec;
    logic [spfd_pkg::WORD_W-1:0]     eff_tof;
    logic [spfd_pkg::WORD_W-1:0]     tof_sum;

    // Clamp the scan count to 1..MAX_SCANS
    always_comb
    begin
        if (scan_count == '0)
        begin
            n_eff = spfd_pkg::HPOS_W'(1);
        end
        else if (32'(scan_count) > 32'(spfd_pkg::MAX_SCANS))
        begin
            n_eff = spfd_pkg::HPOS_W'(spfd_pkg::MAX_SCANS);
        end
        else
        begin
            n_eff = spfd_pkg::HPOS_W'(scan_count);
        end
    end

    assign last_scan = spfd_pkg::SCAN_W'(n_eff - spfd_pkg::HPOS_W'(1));

    // Take words only while not walking the table and the queue has room
    assign word_stall = (state_reg != ST_RUN) || q_full;
    assign accept     = word_valid && !word_stall;

    // Frame start clears position state ahead of this word
    assign start      = word.frame_start;
    assign eff_header = start || in_header_reg;
    assign eff_pos    = start ? '0 : hdr_pos_reg;
    assign eff_expect = !start && expect_reg;
    assign eff_done   = start ? '0 : peaks_done_reg;
    assign eff_cur    = start ? '0 : cur_scan_reg;
    assign eff_left   = start ? '0 : peaks_left_reg;
    assign eff_tof    = start ? '1 : tof_acc_reg;
    assign pos_inc    = eff_pos + spfd_pkg::HPOS_W'(1);
    assign tof_sum    = eff_tof + word.data_word;
    assign left_dec   = (eff_left != '0) ? (eff_left - spfd_pkg::COUNT_W'(1)) : '0;

    // Intensity item for the back part
    always_comb
    begin
        push_job.scan        = cur_scan_reg;
        push_job.tof         = held_tof_reg;
        push_job.intensity   = word.data_word;
        push_job.peak_number = peaks_done_reg;
        push_job.last_peak   = (peak_total != '0) &&
                               (peaks_done_reg == (peak_total - spfd_pkg::WORD_W'(1)));
        push_job.overrun     = (peaks_done_reg >= peak_total);
    end

    // Classify the word and step the position state; walk the table on scan entry
    always_comb
    begin
        state_next      = state_reg;
        in_header_next  = in_header_reg;
        hdr_pos_next    = hdr_pos_reg;
        cur_scan_next   = cur_scan_reg;
        peaks_left_next = peaks_left_reg;
        tof_acc_next    = tof_acc_reg;
        held_tof_next   = held_tof_reg;
        expect_next     = expect_reg;
        peaks_done_next = peaks_done_reg;
        push            = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = spfd_pkg::SCAN_W'(eff_pos - spfd_pkg::HPOS_W'(1));
        wr_data         = word.data_word[spfd_pkg::WORD_W-1:1];

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    in_header_next  = eff_header;
                    hdr_pos_next    = eff_pos;
                    cur_scan_next   = eff_cur;
                    peaks_left_next = eff_left;
                    tof_acc_next    = eff_tof;
                    held_tof_next   = start ? '0 : held_tof_reg;
                    expect_next     = eff_expect;
                    peaks_done_next = eff_done;

                    if (eff_header)
                    begin
                        // Header word: store half the count of the previous scan
                        wr_en        = (eff_pos != '0) && (eff_pos < n_eff);
                        hdr_pos_next = pos_inc;
                        if (pos_inc >= n_eff)
                        begin
                            in_header_next = 1'b0;
                            cur_scan_next  = '0;
                            tof_acc_next   = '1;
                            expect_next    = 1'b0;
                            state_next     = ST_LOOK;
                        end
                    end
                    else if (!eff_expect)
                    begin
                        // Tof delta: accumulate and hold for the intensity
                        tof_acc_next  = tof_sum;
                        held_tof_next = tof_sum;
                        expect_next   = 1'b1;
                    end
                    else
                    begin
                        // Intensity: emit, count the peak, leave an exhausted scan
                        push        = 1'b1;
                        expect_next = 1'b0;
                        if (peaks_done_reg != '1)
                        begin
                            peaks_done_next = peaks_done_reg + spfd_pkg::WORD_W'(1);
                        end
                        if (cur_scan_reg < last_scan)
                        begin
                            peaks_left_next = left_dec;
                            if (left_dec == '0)
                            begin
                                cur_scan_next = cur_scan_reg + spfd_pkg::SCAN_W'(1);
                                tof_acc_next  = '1;
                                state_next    = ST_LOOK;
                            end
                        end
                    end
                end
            end
            ST_LOOK:
            begin
                // Last scan takes all further peaks; otherwise fetch its count
                if (cur_scan_reg == last_scan)
                begin
                    peaks_left_next = '0;
                    state_next      = ST_RUN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Skip an empty scan, else settle on it
                if (rd_data_reg == '0)
                begin
                    cur_scan_next = cur_scan_reg + spfd_pkg::SCAN_W'(1);
                    state_next    = ST_LOOK;
                end
                else
                begin
                    peaks_left_next = rd_data_reg;
                    state_next      = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Count table port: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[cur_scan_reg];
        end
    end

    // Position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            in_header_reg  <= 1'b1;
            hdr_pos_reg    <= '0;
            cur_scan_reg   <= '0;
            peaks_left_reg <= '0;
            tof_acc_reg    <= '1;
            held_tof_reg   <= '0;
            expect_reg     <= 1'b0;
            peaks_done_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            in_header_reg  <= in_header_next;
            hdr_pos_reg    <= hdr_pos_next;
            cur_scan_reg   <= cur_scan_next;
            peaks_left_reg <= peaks_left_next;
            tof_acc_reg    <= tof_acc_next;
            held_tof_reg   <= held_tof_next;
            expect_reg     <= expect_next;
            peaks_done_reg <= peaks_done_next;
        end
    end

endmodule

### src/spfd_queue.sv
// Short queue of intensity items between front and back of the decoder.
// Depends on spfd_pkg.
module spfd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spfd_pkg::job_t  push_job,
    output logic            full,
    output logic            q_valid,
    input  logic            pop,
    output spfd_pkg::job_t  q_job
);

    spfd_pkg::job_t                  slot_reg [spfd_pkg::QUEUE_DEPTH];
    logic [spfd_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [spfd_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [spfd_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full    = (count_reg == spfd_pkg::QCNT_W'(spfd_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + spfd_pkg::QPTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + spfd_pkg::QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + spfd_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - spfd_pkg::QCNT_W'(1);
        end
    end

    // Store an item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/spfd_back.sv
// Back part of the frame decoder: scales intensity by the Q16.16 gain with
// rounding and saturation, and holds the result item. Depends on spfd_pkg.
module spfd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  spfd_pkg::job_t                q_job,
    output logic                          pop,
    input  logic [spfd_pkg::WORD_W-1:0]   intensity_gain,
    output logic                          peak_valid,
    input  logic                          peak_stall,
    output spfd_pkg::peak_t               peak
);

    logic                              mul_vld_reg;
    spfd_pkg::job_t                    mul_job_reg;
    logic [2*spfd_pkg::WORD_W-1:0]     mul_prod_reg;
    logic                              out_vld_reg;
    spfd_pkg::peak_t                   out_reg, out_next;
    logic                              adv_out;
    logic                              adv_mul;
    logic [2*spfd_pkg::WORD_W-1:0]     rounded;

    // Move forward where the next stage is free or draining
    assign adv_out = !out_vld_reg || !peak_stall;
    assign adv_mul = !mul_vld_reg || adv_out;
    assign pop     = q_valid && adv_mul;

    // Round half up, drop the fraction, saturate
    assign rounded = mul_prod_reg + spfd_pkg::ROUND_HALF;

    always_comb
    begin
        out_next.scan_index  = spfd_pkg::OUT_SCAN_W'(mul_job_reg.scan);
        out_next.tof_value   = mul_job_reg.tof;
        out_next.peak_number = mul_job_reg.peak_number;
        out_next.last_peak   = mul_job_reg.last_peak;
        out_next.overrun     = mul_job_reg.overrun;
        if (rounded[2*spfd_pkg::WORD_W-1:spfd_pkg::WORD_W+16] != '0)
        begin
            out_next.scaled_intensity = '1;
        end
        else
        begin
            out_next.scaled_intensity = rounded[spfd_pkg::WORD_W+15:16];
        end
    end

    // Multiply stage and result register payload
    always_ff @(posedge clk)
    begin
        if (adv_mul)
        begin
            mul_job_reg  <= q_job;
            mul_prod_reg <= 64'(q_job.intensity) * 64'(intensity_gain);
        end
        if (adv_out)
        begin
            out_reg <= out_next;
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv_mul)
            begin
                mul_vld_reg <= q_valid;
            end
            if (adv_out)
            begin
                out_vld_reg <= mul_vld_reg;
            end
        end
    end

    assign peak_valid = out_vld_reg;
    assign peak       = out_reg;

endmodule

### src/scan_peak_frame_decoder.sv
// Top level of the scan/peak frame decoder: configuration registers and the
// front, queue and back parts. Depends on spfd_pkg and the spfd_* modules.
//
//   channel | direction | handshake          | item
//   --------+-----------+--------------------+------------------------------
//   word    | in        | word_valid/stall   | data_word, frame_start
//   peak    | out       | peak_valid/stall   | scan, tof, intensity, flags
//   cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
//
// Header, tof and intensity words are taken only in the run state with queue room.
// Entering a scan (after the header or when a scan runs out) walks the count table
// with word stalled: straight back to run if the next scan is the last, else a look
// and a check per table entry examined, plus one more look when the walk ends on the
// last scan, as the table has a single registered port.
// Reset is asynchronous; the count table is not cleared. A held peak stall
// backs up the output register, multiply stage and two-item queue, then stalls word.
module scan_peak_frame_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               word_valid,
    input  spfd_pkg::word_t                    word,
    output logic                               word_stall,
    output logic                               peak_valid,
    input  logic                               peak_stall,
    output spfd_pkg::peak_t                    peak,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spfd_pkg::WORD_W-1:0]        cfg_data
);

    logic [spfd_pkg::SCANCFG_W-1:0]  scan_count_reg;
    logic [spfd_pkg::WORD_W-1:0]     peak_total_reg;
    logic [spfd_pkg::WORD_W-1:0]     intensity_gain_reg;

    logic            q_full;
    logic            push;
    spfd_pkg::job_t  push_job;
    logic            q_valid;
    logic            pop;
    spfd_pkg::job_t  q_job;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_count_reg     <= spfd_pkg::SCAN_COUNT_RST;
            peak_total_reg     <= spfd_pkg::PEAK_TOTAL_RST;
            intensity_gain_reg <= spfd_pkg::INTENSITY_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                spfd_pkg::CFG_SCAN_COUNT:
                begin
                    scan_count_reg <= cfg_data[spfd_pkg::SCANCFG_W-1:0];
                end
                spfd_pkg::CFG_PEAK_TOTAL:
                begin
                    peak_total_reg <= cfg_data;
                end
                spfd_pkg::CFG_INTENSITY_GAIN:
                begin
                    intensity_gain_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    spfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (word),
        .word_stall (word_stall),
        .scan_count (scan_count_reg),
        .peak_total (peak_total_reg),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    spfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .q_valid  (q_valid),
        .pop      (pop),
        .q_job    (q_job)
    );

    spfd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_job          (q_job),
        .pop            (pop),
        .intensity_gain (intensity_gain_reg),
        .peak_valid     (peak_valid),
        .peak_stall     (peak_stall),
        .peak           (peak)
    );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for scan_peak_frame_decoder: framed word streams in,
// every peak predicted and compared field by field. Needs spfd_pkg and the RTL.
module testbench;

    localparam int MAX_SCANS  = spfd_pkg::MAX_SCANS;
    localparam int WORD_W     = spfd_pkg::WORD_W;
    localparam int COUNT_W    = spfd_pkg::COUNT_W;
    localparam int SCANCFG_W  = spfd_pkg::SCANCFG_W;
    localparam int OUT_SCAN_W = spfd_pkg::OUT_SCAN_W;
    localparam int CFG_IDX_W  = spfd_pkg::CFG_IDX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_COUNT     = spfd_pkg::CFG_SCAN_COUNT;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_TOTAL     = spfd_pkg::CFG_PEAK_TOTAL;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_GAIN = spfd_pkg::CFG_INTENSITY_GAIN;

    localparam logic [SCANCFG_W-1:0] SCAN_COUNT_RST     = spfd_pkg::SCAN_COUNT_RST;
    localparam logic [WORD_W-1:0]    PEAK_TOTAL_RST     = spfd_pkg::PEAK_TOTAL_RST;
    localparam logic [WORD_W-1:0]    INTENSITY_GAIN_RST = spfd_pkg::INTENSITY_GAIN_RST;

    typedef spfd_pkg::word_t word_t;
    typedef spfd_pkg::peak_t peak_t;

    localparam int ITEM_GOAL   = 1950;
    localparam int PHASE_WORDS = 110;
    localparam int HOLD_CYCLES = 400;

    // Peak prediction and the store of peaks still to arrive
    class peak_scoreboard;
        logic [SCANCFG_W-1:0] scan_cfg;
        logic [WORD_W-1:0]    total_cfg;
        logic [WORD_W-1:0]    gain_cfg;
        logic [COUNT_W-1:0]   peak_counts [MAX_SCANS];
        bit                   in_hdr;
        int unsigned          hdr_pos;
        int unsigned          scan_now;
        logic [COUNT_W-1:0]   scan_left;
        logic [WORD_W-1:0]    tof_acc;
        logic [WORD_W-1:0]    tof_held;
        bit                   want_intensity;
        logic [WORD_W-1:0]    peak_count;
        peak_t                pending [$];
        int                   errors;
        int                   checked;
        int                   overruns;
        int                   closings;

        function new();
            scan_cfg  = SCAN_COUNT_RST;
            total_cfg = PEAK_TOTAL_RST;
            gain_cfg  = INTENSITY_GAIN_RST;
            foreach (peak_counts[i])
                peak_counts[i] = '0;
            in_hdr         = 1'b1;
            hdr_pos        = 0;
            scan_now       = 0;
            scan_left      = '0;
            tof_acc        = '1;
            tof_held       = '0;
            want_intensity = 1'b0;
            peak_count     = '0;
            errors         = 0;
            checked        = 0;
            overruns       = 0;
            closings       = 0;
        endfunction

        // Scan count as the block uses it: zero means one, clamp at the table size
        function int unsigned active_scans();
            if (scan_cfg == 0)
                return 1;
            if (scan_cfg > MAX_SCANS)
                return MAX_SCANS;
            return 32'(scan_cfg);
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [WORD_W-1:0] val);
            case (idx)
                CFG_SCAN_COUNT:     scan_cfg  = val[SCANCFG_W-1:0];
                CFG_PEAK_TOTAL:     total_cfg = val;
                CFG_INTENSITY_GAIN: gain_cfg  = val;
                default: ;
            endcase
        endfunction

        // Move to scan s, skipping empty ones; the last scan is open ended
        function void enter_scan(input int unsigned s);
            int unsigned last_scan;
            last_scan = active_scans() - 1;
            while (s < last_scan && peak_counts[s] == 0)
                s++;
            if (s > last_scan)
                s = last_scan;
            scan_now       = s;
            scan_left      = (s < last_scan) ? peak_counts[s] : '0;
            tof_acc        = '1;
            want_intensity = 1'b0;
        endfunction

        // Q16.16 gain, round half up, saturate
        function logic [WORD_W-1:0] scaled(input logic [WORD_W-1:0] v);
            logic [2*WORD_W-1:0] prod;
            prod = ({32'b0, v} * {32'b0, gain_cfg} + 64'h8000) >> 16;
            return (prod > 64'hFFFF_FFFF) ? '1 : prod[WORD_W-1:0];
        endfunction

        // Advance the frame state by one accepted item
        function void note_word(input word_t w);
            int unsigned n;
            peak_t       p;
            n = active_scans();
            if (w.frame_start)
            begin
                in_hdr         = 1'b1;
                hdr_pos        = 0;
                scan_now       = 0;
                scan_left      = '0;
                tof_acc        = '1;
                tof_held       = '0;
                want_intensity = 1'b0;
                peak_count     = '0;
            end
            if (in_hdr)
            begin
                if (hdr_pos >= 1 && hdr_pos < n)
                    peak_counts[(hdr_pos - 1) % MAX_SCANS] = w.data_word[WORD_W-1:1];
                hdr_pos++;
                if (hdr_pos >= n)
                begin
                    in_hdr = 1'b0;
                    enter_scan(0);
                end
                return;
            end
            if (!want_intensity)
            begin
                tof_acc        = tof_acc + w.data_word;
                tof_held       = tof_acc;
                want_intensity = 1'b1;
                return;
            end
            p.scan_index       = OUT_SCAN_W'(scan_now);
            p.tof_value        = tof_held;
            p.scaled_intensity = scaled(w.data_word);
            p.peak_number      = peak_count;
            p.last_peak        = (total_cfg != 0) && (peak_count == total_cfg - 1);
            p.overrun          = (peak_count >= total_cfg);
            pending.push_back(p);
            if (peak_count != '1)
                peak_count++;
            want_intensity = 1'b0;
            if (scan_now < n - 1)
            begin
                if (scan_left > 0)
                    scan_left--;
                if (scan_left == 0)
                    enter_scan(scan_now + 1);
            end
        endfunction

        function void check_peak(input peak_t got);
            peak_t want;
            if (got.overrun)
                overruns++;
            if (got.last_peak)
                closings++;
            if (pending.size() == 0)
            begin
                $error("peak with nothing predicted: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.scan_index != want.scan_index)
            begin
                $error("scan_index: expected %0d, got %0d", want.scan_index, got.scan_index);
                errors++;
            end
            if (got.tof_value != want.tof_value)
            begin
                $error("tof_value: expected %h, got %h", want.tof_value, got.tof_value);
                errors++;
            end
            if (got.scaled_intensity != want.scaled_intensity)
            begin
                $error("scaled_intensity: expected %h, got %h",
                       want.scaled_intensity, got.scaled_intensity);
                errors++;
            end
            if (got.peak_number != want.peak_number)
            begin
                $error("peak_number: expected %0d, got %0d", want.peak_number, got.peak_number);
                errors++;
            end
            if (got.last_peak !== want.last_peak)
            begin
                $error("last_peak: expected %b, got %b", want.last_peak, got.last_peak);
                errors++;
            end
            if (got.overrun !== want.overrun)
            begin
                $error("overrun: expected %b, got %b", want.overrun, got.overrun);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 word_valid;
    word_t                word;
    logic                 word_stall;
    logic                 peak_valid;
    logic                 peak_stall;
    peak_t                peak;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    peak_scoreboard sb = new();
    int words_sent    = 0;
    int frames_sent   = 0;
    int settings_run  = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    int holds_served  = 0;

    scan_peak_frame_decoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (word),
        .word_stall (word_stall),
        .peak_valid (peak_valid),
        .peak_stall (peak_stall),
        .peak       (peak),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("scan_peak_frame_decoder test failed");
        $finish;
    end

    // Peak receiver: check each accepted item, stall on a pattern of its own
    initial
    begin
        int stall_pct;
        int mode_left;
        int hold_left;
        stall_pct = 0;
        mode_left = 0;
        hold_left = 0;
        peak_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && peak_valid && !peak_stall)
                sb.check_peak(peak);
            if (holds_served != hold_requests && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                peak_stall <= 1'b1;
            end
            else
                peak_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Mostly empty or short scans, now and then a huge one
    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 7)
            return '0;
        if (r < 18)
            return COUNT_W'($urandom_range(1, 4));
        if (r == 18)
            return COUNT_W'($urandom_range(5, 30));
        return COUNT_W'($urandom >> 1);
    endfunction

    // Offer one item, idling between bursts; returns once it is accepted
    task automatic send_word(input logic [WORD_W-1:0] data, input logic start);
        word_t w;
        int    gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                word_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 20);
        end
        w.data_word   = data;
        w.frame_start = start;
        word_valid <= 1'b1;
        word       <= w;
        @(posedge clk);
        while (word_stall)
            @(posedge clk);
        sb.note_word(w);
        burst_left--;
        words_sent++;
    endtask

    // Write all three registers; the block must be idle
    task automatic write_config(input logic [SCANCFG_W-1:0] sc, input logic [WORD_W-1:0] tot,
                                input logic [WORD_W-1:0] gn);
        logic [WORD_W-1:0]    vals [3];
        logic [CFG_IDX_W-1:0] idxs [3];
        vals = '{WORD_W'(sc), tot, gn};
        idxs = '{CFG_SCAN_COUNT, CFG_PEAK_TOTAL, CFG_INTENSITY_GAIN};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(idxs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // Stop offering, wait for every predicted peak, then let a table walk finish
    task automatic drain();
        word_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2 * sb.active_scans() + 20) @(posedge clk);
    endtask

    // One frame: header with random counts, then tof/intensity pairs;
    // sometimes cut short, sometimes followed by stray words
    task automatic send_frame(input int unsigned n, input logic [WORD_W-1:0] total);
        logic [COUNT_W-1:0] counts [MAX_SCANS];
        longint unsigned    sum;
        int unsigned        npk;
        int unsigned        cut;
        int unsigned        idx;
        int unsigned        style;
        sum = 0;
        for (int s = 0; s < n - 1; s++)
        begin
            counts[s] = pick_count();
            sum += 64'(counts[s]);
        end
        case ($urandom_range(0, 3))
            0: npk = (total <= 64) ? total : $urandom_range(0, 40);
            1: npk = (total <= 64) ? total + $urandom_range(1, 3) : $urandom_range(0, 40);
            2: npk = (sum <= 60) ? 32'(sum) + $urandom_range(0, 4) : $urandom_range(20, 64);
            default: npk = $urandom_range(0, 20);
        endcase
        style = $urandom_range(0, 9);
        cut   = (style == 0) ? $urandom_range(1, n + 2 * npk) : n + 2 * npk + 1;
        frames_sent++;
        send_word(pick_value(), 1'b1);
        idx = 1;
        for (int s = 1; s < n; s++)
        begin
            if (idx == cut)
                return;
            send_word({counts[s-1], 1'($urandom)}, 1'b0);
            idx++;
        end
        for (int k = 0; k < npk; k++)
        begin
            if (idx == cut)
                return;
            send_word(pick_value(), 1'b0);
            idx++;
            if (idx == cut)
                return;
            send_word(pick_value(), 1'b0);
            idx++;
        end
        if (style == 1)
            repeat ($urandom_range(1, 6)) send_word($urandom, $urandom_range(0, 7) == 0);
    endtask

    // Main sequence
    initial
    begin
        logic [SCANCFG_W-1:0] sc;
        logic [WORD_W-1:0]    tot;
        logic [WORD_W-1:0]    gn;
        int                   phase;
        int                   phase_start;
        rst_n      <= 1'b0;
        word_valid <= 1'b0;
        word       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_SCAN_COUNT;
        cfg_data   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No frame start after reset, single scan, reset gain; tof wraps
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h1, 1'b0);
        send_word(32'h0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h1, 1'b0);
        drain();

        // Three scans, middle one empty, saturating gain, run past the total,
        // then a new frame cuts a pair in half and opens a huge first scan
        write_config(11'd3, 32'd3, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h3, 1'b0);
        send_word(32'h0, 1'b0);
        send_word(32'h5, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h10, 1'b0);
        send_word(32'h0, 1'b0);
        send_word(32'h0, 1'b0);
        send_word(32'h1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7, 1'b0);
        send_word(32'h0, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0, 1'b0);
        send_word(32'h1, 1'b0);
        send_word(32'h2, 1'b0);
        drain();

        // Random frames under a series of register settings
        phase = 0;
        while (words_sent < ITEM_GOAL)
        begin
            case (phase)
                1: sc = '0;
                3: sc = '1;
                default: sc = SCANCFG_W'(($urandom_range(0, 4) == 0) ? $urandom_range(13, 64)
                                                                     : $urandom_range(1, 12));
            endcase
            case (phase)
                2: tot = '1;
                4: tot = '0;
                default: tot = $urandom_range(0, 40);
            endcase
            case (phase % 5)
                0: gn = 32'h0001_0000;
                1: gn = '0;
                2: gn = '1;
                3: gn = $urandom;
                default: gn = $urandom_range(0, 32'h3FFFF);
            endcase
            write_config(sc, tot, gn);
            if (phase == 2 || phase == 5)
                hold_requests <= hold_requests + 1;
            phase_start = words_sent;
            do
                send_frame(sb.active_scans(), tot);
            while (words_sent - phase_start < PHASE_WORDS && words_sent < ITEM_GOAL
                   && sb.active_scans() <= 64);
            drain();
            phase++;
        end

        $display("Sent %0d words in %0d frames under %0d register settings",
                 words_sent, frames_sent, settings_run);
        $display("Checked %0d peaks: %0d beyond the peak total, %0d closing it",
                 sb.checked, sb.overruns, sb.closings);
        if (sb.errors == 0)
            $display("scan_peak_frame_decoder test passed");
        else
            $display("scan_peak_frame_decoder test failed");
        $finish;
    end

endmodule
